// ===== src/swlw_pkg.sv =====
package swlw_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int COORD_W    = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SLICE_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_PHASE_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_PHASE_STEP = 3'd5;

   localparam logic        CMD_TICK  = 1'b0;
   localparam logic        CMD_STRIP = 1'b1;

   localparam logic        DEF_SLICE_MODE      = 1'b1;
   localparam logic [11:0] DEF_SCREEN_WIDTH    = 12'd640;
   localparam logic [11:0] DEF_SCREEN_HEIGHT   = 12'd448;
   localparam logic [11:0] DEF_AMPLITUDE       = 12'd384;
   localparam logic [15:0] DEF_LINE_PHASE_STEP = 16'd834;
   localparam logic [15:0] DEF_TIME_PHASE_STEP = 16'd626;

   localparam int DEF_SINE_TABLE_DEPTH = 256;
   localparam int DEF_SCREEN_ORIGIN    = 2048;

   // polynomial sine coefficients, Q15 products
   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [15:0] SIN_C = 16'd2320;

   localparam logic [16:0] Q15_ONE = 17'd32768;

   // pixel count to 12.4 fixed point, wrapped to 16 bits
   function automatic logic [COORD_W-1:0] fx16(input logic [11:0] v);
      return {v, 4'b0000};
   endfunction

endpackage

// ===== src/sine_wave_line_warp_top.sv =====
// Sine wave line warp generator.
// Input channel (req_*): one beat is a command. cmd 0 advances the wave
// phase by time_delta * time_phase_step >> 8 and gives no result. cmd 1
// asks for the corners of strip line_index; an index at or past the screen
// size minus one gives no result.
// Result channel (rsp_*): one beat per valid strip, eight 12.4 coordinates.
// Config port (csr_*): always ready; write only while the block is idle.
// Sequencing: all multiplications run through one 32x32 multiplier under a
// small sequencer, at most one product per cycle. A tick busies it for its
// accumulate step; an out-of-range strip leaves it idle. A strip runs
// through phase, table index, reciprocal divide and correction, four
// polynomial products and amplitude scale; the next beat is taken only
// after its result is loaded. req_stall is high while the sequencer is busy.
// The result sits in an output register; the next item is accepted while it
// waits. If a new result is ready while an unread one is stalled, the
// sequencer holds in its last step until the output register frees up.
// Reset clears the phase, restores the default registers and drops
// rsp_valid.
module sine_wave_line_warp_top #(
   parameter int SINE_TABLE_DEPTH = swlw_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int SCREEN_ORIGIN    = swlw_pkg::DEF_SCREEN_ORIGIN
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [15:0]                         req_time_delta,
   input  logic [10:0]                         req_line_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_u_start,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_v_start,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_x_start,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_y_start,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_u_end,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_v_end,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_x_end,
   output logic [swlw_pkg::COORD_W-1:0]        rsp_y_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swlw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swlw_pkg::CSR_DATA_W-1:0]     csr_data
);
   import swlw_pkg::*;

   localparam int KW = $clog2(SINE_TABLE_DEPTH);
   localparam int NW = KW + 16;
   localparam logic [31:0] DEPTH = 32'(SINE_TABLE_DEPTH);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SINE_TABLE_DEPTH);
   localparam logic [11:0] ORG   = 12'(SCREEN_ORIGIN);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TACC = 4'd1;
   localparam logic [3:0] S_K    = 4'd2;
   localparam logic [3:0] S_QE   = 4'd3;
   localparam logic [3:0] S_QD   = 4'd4;
   localparam logic [3:0] S_QC   = 4'd5;
   localparam logic [3:0] S_X2   = 4'd6;
   localparam logic [3:0] S_T1   = 4'd7;
   localparam logic [3:0] S_T2   = 4'd8;
   localparam logic [3:0] S_T3   = 4'd9;
   localparam logic [3:0] S_D    = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [15:0] phase_ff, phase_in;
   logic        slice_ff, slice_in;
   logic [11:0] width_ff, width_in;
   logic [11:0] height_ff, height_in;
   logic [11:0] amp_ff, amp_in;
   logic [15:0] lstep_ff, lstep_in;
   logic [15:0] tstep_ff, tstep_in;
   logic [10:0] idx_ff, idx_in;
   logic [KW-1:0] k_ff, k_in;
   logic [15:0] qe_ff, qe_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] x2_ff, x2_in;
   logic        neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] u0_out_ff, v0_out_ff, x0_out_ff, y0_out_ff;
   logic [COORD_W-1:0] u1_out_ff, v1_out_ff, x1_out_ff, y1_out_ff;
   logic [COORD_W-1:0] u0_out_in, v0_out_in, x0_out_in, y0_out_in;
   logic [COORD_W-1:0] u1_out_in, v1_out_in, x1_out_in, y1_out_in;

   logic        mul_en;
   logic [31:0] mul_a, mul_b;
   logic        req_take, rsp_take, load_out;
   logic [11:0] size, len, amp2, hw, hh, x0, y0, u0, v0, idx12;
   logic        in_range;
   logic [NW-1:0] n_val, rem;
   logic [15:0] q, qf, t_fin;
   logic [16:0] onep;
   logic [13:0] d;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_u_start = u0_out_ff;
   assign rsp_v_start = v0_out_ff;
   assign rsp_x_start = x0_out_ff;
   assign rsp_y_start = y0_out_ff;
   assign rsp_u_end   = u1_out_ff;
   assign rsp_v_end   = v1_out_ff;
   assign rsp_x_end   = x1_out_ff;
   assign rsp_y_end   = y1_out_ff;

   // strip geometry, all coordinates wrap at 12 integer bits
   assign size     = slice_ff ? width_ff : height_ff;
   assign in_range = (12'({1'b0, req_line_index}) + 12'd1) < size;
   assign amp2     = {3'b000, amp_ff[11:4], 1'b0};
   assign len      = (size >= amp2) ? (size - amp2) : 12'd0;
   assign hw       = {1'b0, width_ff[11:1]};
   assign hh       = {1'b0, height_ff[11:1]};
   assign x0       = ORG - hw;
   assign y0       = ORG - hh;
   assign idx12    = {1'b0, idx_ff};
   assign u0       = slice_ff ? (x0 - ORG + hw) : (x0 + hw - (ORG - 12'd1));
   assign v0       = slice_ff ? (y0 + hh - (ORG - 12'd1)) : (y0 - ORG + hh);

   // reciprocal divide correction: qe is at most one short
   assign n_val = {k_ff, 16'h0000};
   assign rem   = n_val - prod_ff[NW-1:0];
   assign q     = (rem >= NW'(DEPTH)) ? (qe_ff + 16'd1) : qe_ff;
   assign qf    = {1'b0, q[13:0], 1'b0};

   assign t_fin = (prod_ff[31:15] > Q15_ONE) ? 16'h8000 : prod_ff[30:15];
   assign onep  = neg_ff ? (Q15_ONE - 17'(t_fin)) : (Q15_ONE + 17'(t_fin));
   assign d     = prod_ff[28:15];

   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      qe_in     = qe_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      neg_in    = neg_ff;
      mul_en    = 1'b0;
      mul_a     = 32'd0;
      mul_b     = 32'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               idx_in = req_line_index;
               if (req_cmd == CMD_TICK) begin
                  mul_en   = 1'b1;
                  mul_a    = 32'(req_time_delta);
                  mul_b    = 32'(tstep_ff);
                  state_in = S_TACC;
               end else if (in_range) begin
                  mul_en   = 1'b1;
                  mul_a    = 32'(req_line_index);
                  mul_b    = 32'(lstep_ff);
                  state_in = S_K;
               end
            end
         end
         S_TACC: begin
            phase_in = phase_ff + prod_ff[23:8];
            state_in = S_IDLE;
         end
         S_K: begin
            // strip phase wraps at 16 bits before the table lookup
            mul_en   = 1'b1;
            mul_a    = 32'(16'(phase_ff + prod_ff[15:0]));
            mul_b    = DEPTH;
            state_in = S_QE;
         end
         S_QE: begin
            k_in     = prod_ff[KW+15:16];
            mul_en   = 1'b1;
            mul_a    = 32'({prod_ff[KW+15:16], 16'h0000});
            mul_b    = RECIP;
            state_in = S_QD;
         end
         S_QD: begin
            qe_in    = prod_ff[47:32];
            mul_en   = 1'b1;
            mul_a    = 32'(prod_ff[47:32]);
            mul_b    = DEPTH;
            state_in = S_QC;
         end
         S_QC: begin
            // fold the quarter wave onto a Q15 argument
            x_in     = q[14] ? (16'h8000 - qf) : qf;
            neg_in   = q[15];
            state_in = S_X2;
         end
         S_X2: begin
            mul_en   = 1'b1;
            mul_a    = 32'(x_ff);
            mul_b    = 32'(x_ff);
            state_in = S_T1;
         end
         S_T1: begin
            x2_in    = prod_ff[30:15];
            mul_en   = 1'b1;
            mul_a    = 32'(prod_ff[30:15]);
            mul_b    = 32'(SIN_C);
            state_in = S_T2;
         end
         S_T2: begin
            mul_en   = 1'b1;
            mul_a    = 32'(SIN_B - prod_ff[30:15]);
            mul_b    = 32'(x2_ff);
            state_in = S_T3;
         end
         S_T3: begin
            mul_en   = 1'b1;
            mul_a    = 32'(SIN_A - prod_ff[30:15]);
            mul_b    = 32'(x_ff);
            state_in = S_D;
         end
         S_D: begin
            mul_en   = 1'b1;
            mul_a    = 32'(amp_ff);
            mul_b    = 32'(onep);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      prod_in = mul_en ? (64'(mul_a) * 64'(mul_b)) : prod_ff;
   end

   always_comb begin
      if (slice_ff) begin
         u0_out_in = fx16(u0) + 16'(d);
         v0_out_in = fx16(v0 + idx12);
         x0_out_in = fx16(x0);
         y0_out_in = fx16(y0 + idx12);
         u1_out_in = fx16(u0 + len) + 16'(d);
         v1_out_in = fx16(v0 + idx12 + 12'd1);
         x1_out_in = fx16(x0 + width_ff);
         y1_out_in = fx16(y0 + idx12 + 12'd1);
      end else begin
         u0_out_in = fx16(u0 + idx12);
         v0_out_in = fx16(v0) + 16'(d);
         x0_out_in = fx16(x0 + idx12);
         y0_out_in = fx16(y0);
         u1_out_in = fx16(u0 + idx12 + 12'd1);
         v1_out_in = fx16(v0 + len) + 16'(d);
         x1_out_in = fx16(x0 + idx12 + 12'd1);
         y1_out_in = fx16(y0 + height_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      slice_in  = slice_ff;
      width_in  = width_ff;
      height_in = height_ff;
      amp_in    = amp_ff;
      lstep_in  = lstep_ff;
      tstep_in  = tstep_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SLICE_MODE:      slice_in  = csr_data[0];
            REG_SCREEN_WIDTH:    width_in  = csr_data[11:0];
            REG_SCREEN_HEIGHT:   height_in = csr_data[11:0];
            REG_AMPLITUDE:       amp_in    = csr_data[11:0];
            REG_LINE_PHASE_STEP: lstep_in  = csr_data;
            REG_TIME_PHASE_STEP: tstep_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
         slice_ff     <= DEF_SLICE_MODE;
         width_ff     <= DEF_SCREEN_WIDTH;
         height_ff    <= DEF_SCREEN_HEIGHT;
         amp_ff       <= DEF_AMPLITUDE;
         lstep_ff     <= DEF_LINE_PHASE_STEP;
         tstep_ff     <= DEF_TIME_PHASE_STEP;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         slice_ff     <= slice_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         amp_ff       <= amp_in;
         lstep_ff     <= lstep_in;
         tstep_ff     <= tstep_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      k_ff    <= k_in;
      qe_ff   <= qe_in;
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      if (load_out) begin
         u0_out_ff <= u0_out_in;
         v0_out_ff <= v0_out_in;
         x0_out_ff <= x0_out_in;
         y0_out_ff <= y0_out_in;
         u1_out_ff <= u1_out_in;
         v1_out_ff <= v1_out_in;
         x1_out_ff <= x1_out_in;
         y1_out_ff <= y1_out_in;
      end
   end

endmodule

// ===== src/swlw_checker.sv =====
module swlw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_u_start,
   input logic [15:0] rsp_v_end
);
   import swlw_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_u_start) && $stable(rsp_v_end))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // a tick always occupies the sequencer for its accumulate step
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == CMD_TICK |=> req_stall)
      else $error("tick did not occupy the sequencer");

   // a new result only comes out of a busy sequencer
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

endmodule

bind sine_wave_line_warp_top swlw_checker u_swlw_checker (.*);
